### rtl/afc_pkg.sv
// Package for the frustum cull test: constants, request codes, control types.
`default_nettype none
package afc_pkg;
  localparam int NUM_PLANES_DEF = 6;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int COEF_W = 32;
  localparam int IDX_W  = 5;
  localparam int TYPE_W = 2;
  localparam int MAT_DEPTH = 16;

  typedef enum logic [1:0] {
    REQ_LOAD_PLANE = 2'd0,
    REQ_LOAD_MAT   = 2'd1,
    REQ_TEST       = 2'd2,
    REQ_NONE       = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TERM, ST_DOT, ST_CHECK, ST_OUT
  } state_t;
endpackage
`default_nettype wire

### rtl/afc_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface afc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  elem_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] box_min_x, box_min_y, box_min_z;
  logic signed [31:0] box_max_x, box_max_y, box_max_z;
  modport source (output valid, req_type, elem_index, coef_value, box_min_x, box_min_y,
                  box_min_z, box_max_x, box_max_y, box_max_z, input ready);
  modport sink (input valid, req_type, elem_index, coef_value, box_min_x, box_min_y,
                box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface afc_res_if;
  logic valid;
  logic ready;
  logic culled;
  modport source (output valid, culled, input ready);
  modport sink (input valid, culled, output ready);
endinterface
`default_nettype wire

### rtl/aabb_frustum_cull_test_core.sv
// Latency: a load is written at its accept edge; a test result is valid once the plane loop
// ends, sooner when a plane culls early (per plane 16 reads for the 4x4 product, then the
// read data and product registers, 3 dot-product steps, 1 check).
// Throughput: one transaction at a time, as requests are taken only while idle; the terms
// share one multiplier, and a test holds the block until its result is taken.
// Reset: synchronous active-low clears control; stores are undefined until loaded.
`default_nettype none
module aabb_frustum_cull_test_core #(
  parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF,
  parameter int DATA_WIDTH = afc_pkg::DATA_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  afc_req_if.sink   in_req,
  afc_res_if.source out_res
);
  import afc_pkg::*;

  localparam int PDEPTH = NUM_PLANES * 4;
  localparam int PA_W   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int PL_W   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int EFF_W  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  // term sum: four 64-bit products; dist: t(66b) * 32b + t<<16, plus sums
  localparam int T_W    = 2 * EFF_W + 2;
  localparam int D_W    = T_W + EFF_W + 3;

  state_t state_r, state_nxt;
  logic [PL_W-1:0] plane_r;
  logic [1:0]  col_r, row_r;      // matrix column j, term index i
  logic [1:0]  ax_r;
  logic        pipe_r;            // read issue active
  logic        rd_v_r;            // read data valid
  logic [1:0]  pcol_r, prow_r;
  logic signed [T_W-1:0] acc_r;
  logic signed [T_W-1:0] t_r [4];
  logic signed [D_W-1:0] dist_r;
  logic signed [EFF_W-1:0] mn_r [3];
  logic signed [EFF_W-1:0] mx_r [3];
  logic        culled_r, oval_r;

  // sign-extend low EFF_W bits of a coefficient
  function automatic logic [DATA_WIDTH-1:0] fit(input logic [31:0] v);
    logic signed [EFF_W-1:0] s;
    s = v[EFF_W-1:0];
    return DATA_WIDTH'(signed'(s));
  endfunction

  // memories
  logic acc_ok;
  assign acc_ok = in_req.valid && in_req.ready;
  logic p_we, m_we;
  logic [PA_W-1:0] p_raddr;
  logic [3:0] m_raddr;
  logic [DATA_WIDTH-1:0] p_rd, m_rd;
  assign p_we = acc_ok && in_req.req_type == REQ_LOAD_PLANE
                && {1'b0, in_req.elem_index} < 6'(PDEPTH);
  assign m_we = acc_ok && in_req.req_type == REQ_LOAD_MAT
                && in_req.elem_index < 5'(MAT_DEPTH);
  assign p_raddr = PA_W'({plane_r, row_r});
  assign m_raddr = {col_r, row_r};

  afc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(PDEPTH)) u_plane (
    .clk, .we(p_we), .waddr(in_req.elem_index[PA_W-1:0]),
    .wdata(fit(in_req.coef_value)), .raddr(p_raddr), .rdata(p_rd));
  afc_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAT_DEPTH)) u_mat (
    .clk, .we(m_we), .waddr(in_req.elem_index[3:0]),
    .wdata(fit(in_req.coef_value)), .raddr(m_raddr), .rdata(m_rd));

  // product of stored values (one multiplier per cycle, registered)
  logic signed [EFF_W-1:0] pa, ma;
  logic signed [2*EFF_W-1:0] prod_r;
  logic prod_v_r;
  logic [1:0] prod_row_r, prod_col_r;
  assign pa = p_rd[EFF_W-1:0];
  assign ma = m_rd[EFF_W-1:0];

  // dot product multiply: t (T_W) * vertex coord, split into two halves
  logic signed [EFF_W-1:0] vtx;
  logic signed [T_W-1:0] tsel;
  assign tsel = t_r[ax_r];
  assign vtx  = tsel[T_W-1] ? mn_r[ax_r] : mx_r[ax_r];
  localparam int HL = EFF_W + 1;          // low half of t, unsigned
  localparam int HH = T_W - HL;
  logic signed [HL+EFF_W:0] plo;
  logic signed [HH+EFF_W-1:0] phi;
  assign plo = $signed({1'b0, tsel[HL-1:0]}) * vtx;
  assign phi = $signed(tsel[T_W-1:HL]) * vtx;
  logic signed [D_W-1:0] dprod;
  assign dprod = (D_W'(phi) <<< HL) + D_W'(plo);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (acc_ok && in_req.req_type == REQ_TEST) state_nxt = ST_TERM;
      ST_TERM:  if (prod_v_r && prod_col_r == 2'd3 && prod_row_r == 2'd3)
                  state_nxt = ST_DOT;
      ST_DOT:   if (ax_r == 2'd2) state_nxt = ST_CHECK;
      ST_CHECK: if (dist_r[D_W-1] || 32'(plane_r) == NUM_PLANES - 1) state_nxt = ST_OUT;
                else state_nxt = ST_TERM;
      ST_OUT:   if (!oval_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_req.ready = (state_r == ST_IDLE);
  end
  assign out_res.valid  = oval_r;
  assign out_res.culled = culled_r;

  // control: read sequencing, plane loop, result hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r <= 1'b0;
      pipe_r <= 1'b0;
      rd_v_r <= 1'b0;
      prod_v_r <= 1'b0;
      col_r <= '0; row_r <= '0; plane_r <= '0; ax_r <= '0;
    end else begin
      state_r <= state_nxt;
      rd_v_r <= pipe_r;
      prod_v_r <= rd_v_r;
      case (state_r)
        ST_IDLE: begin
          col_r <= '0; row_r <= '0; plane_r <= '0; ax_r <= '0;
          pipe_r <= acc_ok && (in_req.req_type == REQ_TEST);
        end
        ST_TERM: begin
          // step through all 16 addresses, the last one included
          if (pipe_r) begin
            if (col_r == 2'd3 && row_r == 2'd3) pipe_r <= 1'b0;
            else {col_r, row_r} <= {col_r, row_r} + 4'd1;
          end
        end
        ST_DOT: ax_r <= ax_r + 2'd1;
        ST_CHECK: begin
          ax_r <= '0; col_r <= '0; row_r <= '0;
          if (!(dist_r[D_W-1] || 32'(plane_r) == NUM_PLANES - 1)) begin
            plane_r <= plane_r + PL_W'(1);
            pipe_r <= 1'b1;
          end else begin
            oval_r <= 1'b1;
          end
        end
        ST_OUT: if (oval_r && out_res.ready) oval_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pcol_r <= col_r;
    prow_r <= row_r;
    prod_col_r <= pcol_r;
    prod_row_r <= prow_r;
    prod_r <= pa * ma;
    if (state_r == ST_IDLE && acc_ok) begin
      mn_r[0] <= in_req.box_min_x[EFF_W-1:0];
      mn_r[1] <= in_req.box_min_y[EFF_W-1:0];
      mn_r[2] <= in_req.box_min_z[EFF_W-1:0];
      mx_r[0] <= in_req.box_max_x[EFF_W-1:0];
      mx_r[1] <= in_req.box_max_y[EFF_W-1:0];
      mx_r[2] <= in_req.box_max_z[EFF_W-1:0];
    end
    if (state_r == ST_TERM && prod_v_r) begin
      if (prod_row_r == 2'd0) acc_r <= T_W'(prod_r);
      else acc_r <= acc_r + T_W'(prod_r);
      if (prod_row_r == 2'd3) t_r[prod_col_r] <= acc_r + T_W'(prod_r);
    end
    if (state_r == ST_TERM && prod_v_r && prod_col_r == 2'd3 && prod_row_r == 2'd3)
      dist_r <= D_W'(acc_r + T_W'(prod_r)) <<< 16;
    if (state_r == ST_DOT) dist_r <= dist_r + dprod;
    if (state_r == ST_CHECK) culled_r <= dist_r[D_W-1];
  end
endmodule
`default_nettype wire

### rtl/afc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module afc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
